### src/dpb_pkg.sv
`timescale 1ns / 1ps
// Shared widths, reset values, register codes and pipeline control types
// for the depth-to-point back-projection block. Depends on nothing.
package dpb_pkg;

	localparam int DepthW  = 16;
	localparam int CoordW  = 12;
	localparam int CenterW = 16;
	localparam int InvW    = 25;
	localparam int PointW  = 32;
	localparam int MagW    = CoordW + 4;
	localparam int MdW     = MagW + DepthW;
	localparam int ProdW   = MdW + InvW;

	localparam int InDataW  = 40;
	localparam int OutDataW = 80;
	localparam int ApbAddrW = 4;
	localparam int ApbDataW = 32;

	localparam int DefMaxSide     = 4096;
	localparam int DefInvFracBits = 24;

	localparam logic [CenterW-1:0] CenterXReset = 16'd5120;
	localparam logic [CenterW-1:0] CenterYReset = 16'd3840;
	localparam logic [InvW-1:0]    InvFxReset   = 25'd33554;
	localparam logic [InvW-1:0]    InvFyReset   = 25'd33554;

	typedef enum logic [1:0] {
		REG_CENTER_X = 2'd0,
		REG_CENTER_Y = 2'd1,
		REG_INV_FX   = 2'd2,
		REG_INV_FY   = 2'd3
	} reg_idx_t;

	// Load enables for the four pipeline stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	typedef struct packed {
		logic [CenterW-1:0] ppx;
		logic [CenterW-1:0] ppy;
		logic [InvW-1:0]    inv_fx;
		logic [InvW-1:0]    inv_fy;
	} cam_cfg_t;

endpackage

### src/dpb_regs.sv
`timescale 1ns / 1ps
// APB register file holding the camera intrinsics.
// Depends on dpb_pkg.
module dpb_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dpb_pkg::ApbAddrW-1:0] paddr,
	input  logic [dpb_pkg::ApbDataW-1:0] pwdata,
	output logic [dpb_pkg::ApbDataW-1:0] prdata,
	output logic                         pready,
	output dpb_pkg::cam_cfg_t            cfg
);
	import dpb_pkg::*;

	cam_cfg_t cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ppx    <= CenterXReset;
			cfg_q.ppy    <= CenterYReset;
			cfg_q.inv_fx <= InvFxReset;
			cfg_q.inv_fy <= InvFyReset;
		end else if (wr_en) begin
			case (idx)
				REG_CENTER_X: cfg_q.ppx    <= pwdata[CenterW-1:0];
				REG_CENTER_Y: cfg_q.ppy    <= pwdata[CenterW-1:0];
				REG_INV_FX:   cfg_q.inv_fx <= pwdata[InvW-1:0];
				REG_INV_FY:   cfg_q.inv_fy <= pwdata[InvW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_CENTER_X: prdata = ApbDataW'(cfg_q.ppx);
			REG_CENTER_Y: prdata = ApbDataW'(cfg_q.ppy);
			REG_INV_FX:   prdata = ApbDataW'(cfg_q.inv_fx);
			REG_INV_FY:   prdata = ApbDataW'(cfg_q.inv_fy);
			default:      prdata = '0;
		endcase
	end

endmodule

### src/dpb_lane.sv
`timescale 1ns / 1ps
// One axis of the back-projection: offset from center, two multiplies,
// round and saturate over four stages. Depends on dpb_pkg.
module dpb_lane #(
	parameter int MAX_SIDE      = dpb_pkg::DefMaxSide,
	parameter int INV_FRAC_BITS = dpb_pkg::DefInvFracBits
) (
	input  logic                         clk,
	input  dpb_pkg::stage_en_t           en,
	input  logic [dpb_pkg::CoordW-1:0]   coord,
	input  logic [dpb_pkg::CenterW-1:0]  center,
	input  logic [dpb_pkg::DepthW-1:0]   depth_s1,
	input  logic [dpb_pkg::InvW-1:0]     inv,
	output logic [dpb_pkg::PointW-1:0]   point_s4
);
	import dpb_pkg::*;

	localparam int SumW = ProdW + 1;
	localparam logic [MagW:0]    SideMax = (MagW+1)'(MAX_SIDE - 1);
	localparam logic [SumW-1:0]  RoundHalf = SumW'(1) << (INV_FRAC_BITS - 1);
	localparam logic [SumW-1:0]  PosLimit  = SumW'(32'h7FFF_FFFF);
	localparam logic [SumW-1:0]  NegLimit  = SumW'(32'h8000_0000);

	logic [CoordW-1:0] coord_c;
	logic [MagW-1:0]   pos;
	logic              neg;
	logic [MagW-1:0]   mag;
	logic [SumW-1:0]   sum;
	logic [SumW-1:0]   rnd;
	logic [PointW-1:0] rsat;
	logic [PointW-1:0] point_d;

	logic [MagW-1:0]  mag_s1;
	logic             neg_s1, neg_s2, neg_s3;
	logic [MdW-1:0]   md_s2;
	logic [ProdW-1:0] prod_s3;

	always_comb begin
		coord_c = ((MagW+1)'(coord) > SideMax) ? SideMax[CoordW-1:0] : coord;
		pos     = {coord_c, 4'b0000};
		neg     = pos < center;
		mag     = neg ? (center - pos) : (pos - center);
	end

	always_comb begin
		sum = {1'b0, prod_s3} + RoundHalf;
		rnd = sum >> INV_FRAC_BITS;
		if (neg_s3) begin
			rsat    = (rnd > NegLimit) ? NegLimit[PointW-1:0] : rnd[PointW-1:0];
			point_d = PointW'(0) - rsat;
		end else begin
			rsat    = (rnd > PosLimit) ? PosLimit[PointW-1:0] : rnd[PointW-1:0];
			point_d = rsat;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			mag_s1 <= mag;
			neg_s1 <= neg;
		end
		if (en.s2) begin
			md_s2  <= mag_s1 * depth_s1;
			neg_s2 <= neg_s1;
		end
		if (en.s3) begin
			prod_s3 <= md_s2 * inv;
			neg_s3  <= neg_s2;
		end
		if (en.s4) begin
			point_s4 <= point_d;
		end
	end

endmodule

### src/depth_to_point_backprojection_top.sv
`timescale 1ns / 1ps
// Top level of the depth-to-point back-projection block: stream control,
// side-band pipeline and two axis lanes. Depends on dpb_pkg, dpb_regs, dpb_lane.
//
//  port group   dir  contents
//  s_axis_*     in   depth pixel: depth, column, row; tlast = end of frame
//  m_axis_*     out  3-D point: x, y, z; tuser = point valid; tlast = end of frame
//  APB          in   ppx, ppy, inv_fx, inv_fy at 0x0, 0x4, 0x8, 0xC
//
// One word per cycle sustained while the output accepts; each word passes from
// input to output register through the offset stage, the two multiplier stages
// and the rounding stage.
// Each stage loads when it is empty or the next one moves, so a stall on the
// output fills bubbles first and then back-pressures the input.
// Reset clears all stage valid bits and loads the default intrinsics.
module depth_to_point_backprojection_top #(
	parameter int MAX_SIDE      = dpb_pkg::DefMaxSide,
	parameter int INV_FRAC_BITS = dpb_pkg::DefInvFracBits
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// depth_mm[15:0], pixel_column[27:16], pixel_row[39:28]
	input  logic [dpb_pkg::InDataW-1:0]   s_tdata,
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// point_x[31:0], point_y[63:32], point_z[79:64]
	output logic [dpb_pkg::OutDataW-1:0]  m_tdata,
	// point_valid[0]
	output logic                          m_tuser,
	output logic                          m_tlast,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dpb_pkg::ApbAddrW-1:0]  paddr,
	input  logic [dpb_pkg::ApbDataW-1:0]  pwdata,
	output logic [dpb_pkg::ApbDataW-1:0]  prdata,
	output logic                          pready
);
	import dpb_pkg::*;

	cam_cfg_t  cfg;
	stage_en_t en;

	logic [DepthW-1:0] depth_in;
	logic [CoordW-1:0] col_in;
	logic [CoordW-1:0] row_in;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic last_s1, last_s2, last_s3, last_s4;
	logic [DepthW-1:0] depth_s1, depth_s2, depth_s3, depth_s4;
	logic [PointW-1:0] x_s4, y_s4;

	assign depth_in = s_tdata[15:0];
	assign col_in   = s_tdata[27:16];
	assign row_in   = s_tdata[39:28];

	// Each stage advances when empty or when the stage after it advances.
	always_comb begin
		en.s4 = !vld_s4 | m_tready;
		en.s3 = !vld_s3 | en.s4;
		en.s2 = !vld_s2 | en.s3;
		en.s1 = !vld_s1 | en.s2;
	end
	assign s_tready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en.s1) vld_s1 <= s_tvalid;
			if (en.s2) vld_s2 <= vld_s1;
			if (en.s3) vld_s3 <= vld_s2;
			if (en.s4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			depth_s1 <= depth_in;
			last_s1  <= s_tlast;
		end
		if (en.s2) begin
			depth_s2 <= depth_s1;
			last_s2  <= last_s1;
		end
		if (en.s3) begin
			depth_s3 <= depth_s2;
			last_s3  <= last_s2;
		end
		if (en.s4) begin
			depth_s4 <= depth_s3;
			last_s4  <= last_s3;
		end
	end

	dpb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Zero depth yields a zero product, so missing points come out as zero.
	dpb_lane #(
		.MAX_SIDE      (MAX_SIDE),
		.INV_FRAC_BITS (INV_FRAC_BITS)
	) u_lane_x (
		.clk      (clk),
		.en       (en),
		.coord    (col_in),
		.center   (cfg.ppx),
		.depth_s1 (depth_s1),
		.inv      (cfg.inv_fx),
		.point_s4 (x_s4)
	);

	dpb_lane #(
		.MAX_SIDE      (MAX_SIDE),
		.INV_FRAC_BITS (INV_FRAC_BITS)
	) u_lane_y (
		.clk      (clk),
		.en       (en),
		.coord    (row_in),
		.center   (cfg.ppy),
		.depth_s1 (depth_s1),
		.inv      (cfg.inv_fy),
		.point_s4 (y_s4)
	);

	assign m_tvalid = vld_s4;
	assign m_tdata  = {depth_s4, y_s4, x_s4};
	assign m_tuser  = depth_s4 != '0;
	assign m_tlast  = last_s4;

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for depth_to_point_backprojection_top: streams depth pixels
// with random gaps and stalls, predicts each point, and checks every output word.
// Depends on dpb_pkg and the RTL top level.
module testbench;
	import dpb_pkg::*;

	localparam int NumPhases    = 8;
	localparam int RandPerPhase = 166;
	localparam int StallLimit   = 1000;
	localparam int TailCycles   = 10;

	typedef struct packed {
		logic [DepthW-1:0] depth;
		logic [CoordW-1:0] col;
		logic [CoordW-1:0] row;
		logic              frame_end;
	} pixel_t;

	typedef struct packed {
		logic [PointW-1:0] x;
		logic [PointW-1:0] y;
		logic [DepthW-1:0] z;
		logic              valid;
		logic              frame_end;
	} point_t;

	class point_scoreboard;
		logic [CenterW-1:0] ppx;
		logic [CenterW-1:0] ppy;
		logic [InvW-1:0]    inv_fx;
		logic [InvW-1:0]    inv_fy;
		point_t expected_points[$];
		int pixels_seen;
		int points_checked;
		int missing_seen;
		int saturated_seen;
		int mismatches;

		function new();
			ppx = CenterXReset;
			ppy = CenterYReset;
			inv_fx = InvFxReset;
			inv_fy = InvFyReset;
			pixels_seen = 0;
			points_checked = 0;
			missing_seen = 0;
			saturated_seen = 0;
			mismatches = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [ApbDataW-1:0] value);
			case (idx)
				REG_CENTER_X: ppx = value[CenterW-1:0];
				REG_CENTER_Y: ppy = value[CenterW-1:0];
				REG_INV_FX:   inv_fx = value[InvW-1:0];
				REG_INV_FY:   inv_fy = value[InvW-1:0];
				default: ;
			endcase
		endfunction

		// Offset from the principal point times depth times 1/f, rounded with halves
		// away from zero, then clipped to signed 32 bits. A 12-bit coordinate never
		// exceeds MAX_SIDE - 1, so no coordinate clamp is needed here.
		function logic [PointW-1:0] backproject(logic [CoordW-1:0] coord,
				logic [CenterW-1:0] center, logic [DepthW-1:0] depth, logic [InvW-1:0] inv);
			longint unsigned pos;
			longint unsigned offset;
			longint unsigned prod;
			longint unsigned mag;
			bit below;
			pos = 64'(coord) << 4;
			below = pos < 64'(center);
			offset = below ? 64'(center) - pos : pos - 64'(center);
			prod = offset * 64'(depth) * 64'(inv);
			mag = (prod + (64'd1 << (DefInvFracBits - 1))) >> DefInvFracBits;
			if (below) begin
				if (mag > 64'h8000_0000)
					mag = 64'h8000_0000;
				return PointW'(64'd0 - mag);
			end
			if (mag > 64'h7FFF_FFFF)
				mag = 64'h7FFF_FFFF;
			return PointW'(mag);
		endfunction

		function void note_pixel(pixel_t p);
			point_t pt;
			pixels_seen++;
			pt = '0;
			if (p.depth == '0) begin
				missing_seen++;
			end else begin
				pt.x = backproject(p.col, ppx, p.depth, inv_fx);
				pt.y = backproject(p.row, ppy, p.depth, inv_fy);
				pt.z = p.depth;
				pt.valid = 1'b1;
				if (pt.x == 32'h7FFF_FFFF || pt.x == 32'h8000_0000)
					saturated_seen++;
				if (pt.y == 32'h7FFF_FFFF || pt.y == 32'h8000_0000)
					saturated_seen++;
			end
			pt.frame_end = p.frame_end;
			expected_points.push_back(pt);
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= 40)
				$display("[%0t] MISMATCH: %s", $realtime, msg);
		endtask

		task check_point(point_t got);
			point_t want;
			if (expected_points.size() == 0) begin
				report($sformatf("point with no pixel pending: x=%0d y=%0d z=%0d",
					$signed(got.x), $signed(got.y), got.z));
				return;
			end
			want = expected_points.pop_front();
			points_checked++;
			if (got.x !== want.x)
				report($sformatf("point %0d x: got %0d, want %0d", points_checked,
					$signed(got.x), $signed(want.x)));
			if (got.y !== want.y)
				report($sformatf("point %0d y: got %0d, want %0d", points_checked,
					$signed(got.y), $signed(want.y)));
			if (got.z !== want.z)
				report($sformatf("point %0d z: got %0d, want %0d", points_checked,
					got.z, want.z));
			if (got.valid !== want.valid)
				report($sformatf("point %0d valid: got %b, want %b", points_checked,
					got.valid, want.valid));
			if (got.frame_end !== want.frame_end)
				report($sformatf("point %0d last: got %b, want %b", points_checked,
					got.frame_end, want.frame_end));
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata = '0;
	logic                s_tlast = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OutDataW-1:0] m_tdata;
	logic                m_tuser;
	logic                m_tlast;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ApbAddrW-1:0] paddr = '0;
	logic [ApbDataW-1:0] pwdata = '0;
	logic [ApbDataW-1:0] prdata;
	logic                pready;

	point_scoreboard sb;
	bit calm = 1'b0;
	int stuck_cycles = 0;

	depth_to_point_backprojection_top DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	always #6 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Bias toward the image edges and the principal point.
	function automatic logic [CoordW-1:0] pick_coord(logic [CenterW-1:0] center);
		int r;
		int v;
		r = $urandom_range(9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (r == 2) begin
			v = int'(center >> 4) + int'($urandom_range(2)) - 1;
			if (v < 0)
				v = 0;
			if (v > 4095)
				v = 4095;
			return CoordW'(v);
		end
		return CoordW'($urandom_range(4095));
	endfunction

	function automatic pixel_t random_pixel(logic [CenterW-1:0] cx, logic [CenterW-1:0] cy);
		pixel_t p;
		int r;
		r = $urandom_range(9);
		if (r == 0)
			p.depth = '0;
		else if (r == 1)
			p.depth = '1;
		else if (r == 2)
			p.depth = DepthW'($urandom_range(1, 15));
		else
			p.depth = DepthW'($urandom_range(65535));
		p.col = pick_coord(cx);
		p.row = pick_coord(cy);
		p.frame_end = ($urandom_range(7) == 0);
		return p;
	endfunction

	task automatic send_pixel(input pixel_t p);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {p.row, p.col, p.depth};
		s_tlast <= p.frame_end;
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop valid, let every pending point come out, then let the pipe settle.
	task automatic drain_points();
		s_tvalid <= 1'b0;
		while (sb.expected_points.size() != 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [ApbDataW-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, value);
	endtask

	task automatic set_camera(input logic [ApbDataW-1:0] cx, input logic [ApbDataW-1:0] cy,
			input logic [ApbDataW-1:0] ifx, input logic [ApbDataW-1:0] ify);
		apb_write(REG_CENTER_X, cx);
		apb_write(REG_CENTER_Y, cy);
		apb_write(REG_INV_FX, ifx);
		apb_write(REG_INV_FY, ify);
	endtask

	task automatic set_phase_camera(input int phase);
		case (phase)
			1: set_camera(0, 0, 0, 0);
			2: set_camera(32'hFFFF, 32'hFFFF, 32'h1FF_FFFF, 32'h1FF_FFFF);
			3: set_camera(0, 0, 32'h1FF_FFFF, 32'h1FF_FFFF);
			// Centers one sixteenth off pixel 100 with 1/f = 0.5 land on exact halves.
			4: set_camera(1601, 1599, 32'h80_0000, 32'h80_0000);
			5: set_camera($urandom_range(65535), $urandom_range(65535),
				32'h100_0000, 32'h100_0000);
			6: set_camera($urandom_range(65535), $urandom_range(65535),
				$urandom_range(16000, 70000), $urandom_range(16000, 70000));
			default: set_camera($urandom, $urandom, $urandom, $urandom);
		endcase
	endtask

	task automatic run_directed();
		send_pixel('{depth: 16'd0, col: 12'd4095, row: 12'd4095, frame_end: 1'b1});
		send_pixel('{depth: 16'hFFFF, col: 12'd0, row: 12'd0, frame_end: 1'b0});
		send_pixel('{depth: 16'hFFFF, col: 12'd4095, row: 12'd4095, frame_end: 1'b1});
		send_pixel('{depth: 16'hFFFF, col: 12'd0, row: 12'd4095, frame_end: 1'b0});
		send_pixel('{depth: 16'd1, col: 12'd100, row: 12'd100, frame_end: 1'b0});
		send_pixel('{depth: 16'd1, col: 12'd320, row: 12'd240, frame_end: 1'b0});
		send_pixel('{depth: 16'hAAAA, col: 12'h555, row: 12'hAAA, frame_end: 1'b1});
		send_pixel('{depth: 16'h5555, col: 12'hAAA, row: 12'h555, frame_end: 1'b0});
	endtask

	// Output stall generator.
	initial begin
		int gap;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = calm ? 0 : pick_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// Monitors and watchdog: sample both stream sides at the rising edge.
	always @(posedge clk) begin
		pixel_t seen;
		point_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				seen.depth = s_tdata[15:0];
				seen.col = s_tdata[27:16];
				seen.row = s_tdata[39:28];
				seen.frame_end = s_tlast;
				sb.note_pixel(seen);
			end
			if (m_tvalid && m_tready) begin
				got.x = m_tdata[31:0];
				got.y = m_tdata[63:32];
				got.z = m_tdata[79:64];
				got.valid = m_tuser;
				got.frame_end = m_tlast;
				sb.check_point(got);
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= StallLimit) begin
				$display("Watchdog: no word moved for %0d cycles, %0d points still due",
					StallLimit, sb.expected_points.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int phase = 0; phase < NumPhases; phase++) begin
			if (phase > 0) begin
				drain_points();
				set_phase_camera(phase);
			end
			if (phase == 0 || phase == 2 || phase == 3 || phase == 4)
				run_directed();
			for (int i = 0; i < RandPerPhase; i++) begin
				if (i % 40 == 0)
					calm = ($urandom_range(3) == 0);
				send_pixel(random_pixel(sb.ppx, sb.ppy));
			end
		end
		drain_points();
		$display("Streamed %0d depth pixels over %0d camera settings, %0d with missing depth;",
			sb.pixels_seen, NumPhases, sb.missing_seen);
		$display("%0d points compared, %0d coordinates at the saturation limits.",
			sb.points_checked, sb.saturated_seen);
		if (sb.mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
